FILE: src/dcbd_pkg.sv
// Package for the dual-CPU bus decoder: memory sizes, map constants,
// opcode/route codes and the command struct passed from front to back.
// No dependencies.
package dcbd_pkg;

    localparam int WORK_RAM_DEPTH  = 65536;
    localparam int SOUND_RAM_DEPTH = 8192;
    localparam int WR_AW = $clog2(WORK_RAM_DEPTH);
    localparam int SR_AW = $clog2(SOUND_RAM_DEPTH);

    // power-on clear sweeps both RAMs in parallel
    localparam int CLR_DEPTH = (WORK_RAM_DEPTH > SOUND_RAM_DEPTH) ?
                               WORK_RAM_DEPTH : SOUND_RAM_DEPTH;
    localparam int CLR_W = $clog2(CLR_DEPTH) + 1;

    // index mod depth via reciprocal: q = (x * RECIP) >> RECIP_SHIFT
    localparam int RECIP_SHIFT = 33;
    localparam logic [23:0] WR_RECIP =
        24'(((64'd1 << RECIP_SHIFT) + 64'(WORK_RAM_DEPTH) - 64'd1) / 64'(WORK_RAM_DEPTH));
    localparam logic [23:0] SR_RECIP =
        24'(((64'd1 << RECIP_SHIFT) + 64'(SOUND_RAM_DEPTH) - 64'd1) / 64'(SOUND_RAM_DEPTH));

    localparam logic [23:0] CART_END      = 24'h400000;
    localparam logic [23:0] SRAM_BASE     = 24'h200000;
    localparam logic [23:0] SOUND_BASE    = 24'hA00000;
    localparam logic [23:0] FM_BASE       = 24'hA04000;
    localparam logic [23:0] IO_BASE       = 24'hA10000;
    localparam logic [23:0] BUSREQ_ADDR_A = 24'hA11000;
    localparam logic [23:0] BUSREQ_ADDR_B = 24'hA11100;
    localparam logic [23:0] RESET_REG     = 24'hA11200;
    localparam logic [23:0] BANK_ADDR     = 24'hA14000;
    localparam logic [23:0] VIDEO_BASE    = 24'hC00000;
    localparam logic [23:0] WORK_RAM_BASE = 24'hE00000;
    localparam logic [7:0]  VERSION_BYTE  = 8'hA0;
    localparam logic [15:0] HCOUNT_ADDR   = 16'h7F00;
    localparam logic [15:0] BANK_REG_END  = 16'h6100;

    localparam logic [4:0] IO_VERSION = 5'h00;
    localparam logic [4:0] IO_PAD     = 5'h03;
    localparam logic [4:0] IO_CTRL_A  = 5'h05;
    localparam logic [4:0] IO_CTRL_B  = 5'h07;
    localparam logic [4:0] IO_PAD_SEL = 5'h09;

    localparam int IN_W  = 56;
    localparam int OUT_W = 48;

    typedef enum logic [1:0] {
        OP_MAIN_RD,
        OP_MAIN_WR,
        OP_SND_RD,
        OP_SND_WR
    } op_t;

    typedef enum logic [2:0] {
        ROUTE_INTERNAL,
        ROUTE_CART_RD,
        ROUTE_SRAM_WR,
        ROUTE_VIDEO,
        ROUTE_FM_ADDR,
        ROUTE_FM_DATA
    } route_t;

    typedef enum logic [1:0] {
        MEM_NONE,
        MEM_WORK,
        MEM_SOUND
    } mem_sel_t;

    // first member lands in the top bits: read_data ends up at bit 0
    typedef struct packed {
        logic        sound_cpu_stalled;
        logic        sound_reset_pulse;
        logic        fm_port;
        logic [7:0]  target_data;
        logic [23:0] target_address;
        route_t      route;
        logic [7:0]  read_data;
    } result_t;

    typedef struct packed {
        mem_sel_t    mem_sel;
        logic        mem_we;
        logic [15:0] idx_raw;
        logic [15:0] quot;
        logic [7:0]  wdata;
        result_t     res;
    } cmd_t;

endpackage

FILE: src/dcbd_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module dcbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end

endmodule

FILE: src/dcbd_front.sv
// Front end: accepts transactions, decodes them against the memory map and
// owns the bus-request, sound-reset, bank and pad-select registers. Uses dcbd_pkg.
module dcbd_front
    import dcbd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    input  logic            q_full,
    input  logic            clr_done,
    output logic            push,
    output cmd_t            cmd
);

    logic       breq_reg, breq_next;
    logic       srst_reg, srst_next;
    logic [7:0] bank_reg, bank_next;
    logic       padsel_reg, padsel_next;

    op_t         op;
    logic [23:0] addr;
    logic [7:0]  wd;
    logic [7:0]  pad;
    logic [8:0]  hpos;
    logic [15:0] s;
    logic [23:0] ma;
    logic [14:0] off;
    logic        wr;
    logic [39:0] prod;

    assign op   = op_t'(s_tdata[1:0]);
    assign addr = s_tdata[25:2];
    assign wd   = s_tdata[33:26];
    assign pad  = s_tdata[41:34];
    assign hpos = s_tdata[50:42];
    assign s    = addr[15:0];
    assign wr   = s_tdata[0];
    // window: bank * 8000h + (s - 8000h)
    assign ma   = (op == OP_MAIN_RD || op == OP_MAIN_WR) ? addr
                : ({1'b0, bank_reg, 15'b0} + {9'b0, s[14:0]});
    assign off  = ma[14:0];

    assign s_tready = !q_full && clr_done;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        cmd         = '0;
        breq_next   = breq_reg;
        srst_next   = srst_reg;
        bank_next   = bank_reg;
        padsel_next = padsel_reg;
        cmd.wdata   = wd;
        cmd.mem_we  = wr;

        if (op == OP_MAIN_RD || op == OP_MAIN_WR || s[15])
        begin
            if (!wr)
            begin
                priority if (ma < CART_END)
                begin
                    cmd.res.route          = ROUTE_CART_RD;
                    cmd.res.target_address = ma;
                end
                else if (ma[23:2] == FM_BASE[23:2])
                    cmd.res.read_data = 8'h00;
                else if (ma[23:16] == SOUND_BASE[23:16])
                begin
                    if (breq_reg || off >= 15'h4000)
                        cmd.res.read_data = 8'hFF;
                    else
                    begin
                        cmd.mem_sel = MEM_SOUND;
                        cmd.idx_raw = {3'b0, off[12:0]};
                    end
                end
                else if (ma[23:5] == IO_BASE[23:5])
                begin
                    unique case (ma[4:0])
                        IO_VERSION: cmd.res.read_data = VERSION_BYTE;
                        IO_PAD:     cmd.res.read_data = padsel_reg ? {4'h3, pad[3:0]}
                                                                   : {4'h7, pad[7:4]};
                        IO_CTRL_A,
                        IO_CTRL_B:  cmd.res.read_data = 8'h7F;
                        default:    cmd.res.read_data = 8'h00;
                    endcase
                end
                else if (ma[23:5] == VIDEO_BASE[23:5])
                begin
                    cmd.res.route          = ROUTE_VIDEO;
                    cmd.res.target_address = ma;
                end
                else if (ma >= WORK_RAM_BASE)
                begin
                    cmd.mem_sel = MEM_WORK;
                    cmd.idx_raw = ma[15:0];
                end
                else
                    cmd.res.read_data = 8'hFF;
            end
            else
            begin
                priority if (ma[23:16] == SRAM_BASE[23:16])
                begin
                    cmd.res.route          = ROUTE_SRAM_WR;
                    cmd.res.target_address = ma;
                    cmd.res.target_data    = wd;
                end
                else if (ma < CART_END)
                begin
                end
                else if (ma[23:2] == FM_BASE[23:2])
                begin
                    cmd.res.route          = ma[0] ? ROUTE_FM_DATA : ROUTE_FM_ADDR;
                    cmd.res.fm_port        = ma[1];
                    cmd.res.target_address = {FM_BASE[23:2], ma[1:0]};
                    cmd.res.target_data    = wd;
                end
                else if (ma[23:16] == SOUND_BASE[23:16])
                begin
                    if (!breq_reg && off < 15'h4000)
                    begin
                        cmd.mem_sel = MEM_SOUND;
                        cmd.idx_raw = {3'b0, off[12:0]};
                    end
                end
                else if (ma[23:5] == IO_BASE[23:5])
                begin
                    if (ma[4:0] == IO_PAD_SEL)
                        padsel_next = wd[6];
                end
                else if (ma == BUSREQ_ADDR_A || ma == BUSREQ_ADDR_B)
                    breq_next = wd[0];
                else if (ma == RESET_REG)
                begin
                    srst_next                 = wd[0];
                    cmd.res.sound_reset_pulse = wd[0];
                end
                else if (ma == BANK_ADDR)
                    bank_next = wd;
                else if (ma[23:5] == VIDEO_BASE[23:5])
                begin
                    cmd.res.route          = ROUTE_VIDEO;
                    cmd.res.target_address = ma;
                    cmd.res.target_data    = wd;
                end
                else if (ma >= WORK_RAM_BASE)
                begin
                    cmd.mem_sel = MEM_WORK;
                    cmd.idx_raw = ma[15:0];
                end
            end
        end
        else
        begin
            // sound CPU, low map
            if (!wr)
            begin
                priority if (s < 16'h4000)
                begin
                    cmd.mem_sel = MEM_SOUND;
                    cmd.idx_raw = {3'b0, s[12:0]};
                end
                else if (s == HCOUNT_ADDR)
                    cmd.res.read_data = hpos[8:1];
                else
                    cmd.res.read_data = 8'h00;
            end
            else
            begin
                priority if (s < 16'h4000)
                begin
                    cmd.mem_sel = MEM_SOUND;
                    cmd.idx_raw = {3'b0, s[12:0]};
                end
                else if (s < 16'h6000)
                begin
                    cmd.res.route          = s[0] ? ROUTE_FM_DATA : ROUTE_FM_ADDR;
                    cmd.res.fm_port        = s[1];
                    cmd.res.target_address = {FM_BASE[23:2], s[1:0]};
                    cmd.res.target_data    = wd;
                end
                else if (s < BANK_REG_END)
                    bank_next = wd;
                else
                begin
                end
            end
        end

        cmd.res.sound_cpu_stalled = breq_next | srst_next;
        prod     = 40'(cmd.idx_raw) * 40'((cmd.mem_sel == MEM_WORK) ? WR_RECIP : SR_RECIP);
        cmd.quot = 16'(prod >> RECIP_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            breq_reg   <= 1'b0;
            srst_reg   <= 1'b1;
            bank_reg   <= 8'h00;
            padsel_reg <= 1'b0;
        end
        else if (push)
        begin
            breq_reg   <= breq_next;
            srst_reg   <= srst_next;
            bank_reg   <= bank_next;
            padsel_reg <= padsel_next;
        end
    end

endmodule

FILE: src/dcbd_queue.sv
// Two-entry command queue between decoder front end and RAM back end.
// Uses dcbd_pkg.
module dcbd_queue
    import dcbd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    assign wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
    assign count_next  = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/dcbd_back.sv
// Back end: power-on RAM clear, work/sound RAM accesses and the output
// register stage. Uses dcbd_pkg and dcbd_ram.
module dcbd_back
    import dcbd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  cmd_t             q_cmd,
    output logic             pop,
    output logic             clr_done,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    logic [CLR_W-1:0] clr_cnt_reg;
    logic             clearing;

    logic     b_valid_reg;
    result_t  b_res_reg;
    mem_sel_t b_rd_sel_reg;
    logic     out_valid_reg;
    result_t  out_res_reg;
    result_t  merged;
    logic     out_load;
    logic     b_free;

    logic [31:0]      wr_full, sr_full;
    logic [WR_AW-1:0] wr_idx;
    logic [SR_AW-1:0] sr_idx;
    logic             wr_en, wr_we, sr_en, sr_we;
    logic [WR_AW-1:0] wr_addr;
    logic [SR_AW-1:0] sr_addr;
    logic [7:0]       wr_wdata, sr_wdata, wr_rdata, sr_rdata;

    assign clearing = clr_cnt_reg != CLR_W'(CLR_DEPTH);
    assign clr_done = !clearing;

    assign out_load = b_valid_reg && (!out_valid_reg || m_tready);
    assign b_free   = !b_valid_reg || out_load;
    assign pop      = q_valid && b_free && !clearing;

    // remainder from the front end's reciprocal quotient
    assign wr_full = 32'(q_cmd.idx_raw) - 32'(q_cmd.quot) * 32'(WORK_RAM_DEPTH);
    assign sr_full = 32'(q_cmd.idx_raw) - 32'(q_cmd.quot) * 32'(SOUND_RAM_DEPTH);
    assign wr_idx  = wr_full[WR_AW-1:0];
    assign sr_idx  = sr_full[SR_AW-1:0];

    always_comb
    begin
        if (clearing)
        begin
            wr_en    = clr_cnt_reg < CLR_W'(WORK_RAM_DEPTH);
            wr_we    = 1'b1;
            wr_addr  = clr_cnt_reg[WR_AW-1:0];
            wr_wdata = 8'h00;
            sr_en    = clr_cnt_reg < CLR_W'(SOUND_RAM_DEPTH);
            sr_we    = 1'b1;
            sr_addr  = clr_cnt_reg[SR_AW-1:0];
            sr_wdata = 8'h00;
        end
        else
        begin
            wr_en    = pop && q_cmd.mem_sel == MEM_WORK;
            wr_we    = q_cmd.mem_we;
            wr_addr  = wr_idx;
            wr_wdata = q_cmd.wdata;
            sr_en    = pop && q_cmd.mem_sel == MEM_SOUND;
            sr_we    = q_cmd.mem_we;
            sr_addr  = sr_idx;
            sr_wdata = q_cmd.wdata;
        end
    end

    dcbd_ram #(.WIDTH(8), .DEPTH(WORK_RAM_DEPTH)) u_work_ram (
        .clk   (clk),
        .en    (wr_en),
        .we    (wr_we),
        .addr  (wr_addr),
        .wdata (wr_wdata),
        .rdata (wr_rdata)
    );

    dcbd_ram #(.WIDTH(8), .DEPTH(SOUND_RAM_DEPTH)) u_sound_ram (
        .clk   (clk),
        .en    (sr_en),
        .we    (sr_we),
        .addr  (sr_addr),
        .wdata (sr_wdata),
        .rdata (sr_rdata)
    );

    always_comb
    begin
        merged = b_res_reg;
        unique case (b_rd_sel_reg)
            MEM_WORK:  merged.read_data = wr_rdata;
            MEM_SOUND: merged.read_data = sr_rdata;
            default:   merged.read_data = b_res_reg.read_data;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            b_res_reg <= q_cmd.res;
        if (out_load)
            out_res_reg <= merged;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            b_valid_reg   <= 1'b0;
            b_rd_sel_reg  <= MEM_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (b_free)
                b_valid_reg <= pop;
            if (pop)
                b_rd_sel_reg <= q_cmd.mem_we ? MEM_NONE : q_cmd.mem_sel;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg};

endmodule

FILE: src/dual_cpu_bus_decoder.sv
// Top level of the dual-CPU bus decoder: front end, command queue, back end.
// Uses dcbd_pkg, dcbd_front, dcbd_queue, dcbd_back.
//
//  channel | dir | payload
//  s_axis  | in  | one byte access (opcode, address, write_data, pad_lines, h_position)
//  m_axis  | out | one decode result per access
//
// One transaction per cycle sustained while the queue has room and m_tready is high;
// each passes decode into queue, RAM access and output register, the RAM read registered.
// After reset, s_tready stays low while both RAMs are cleared.
// The two-entry queue and the output register let input and output stall apart.
module dual_cpu_bus_decoder
    import dcbd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // opcode[1:0], address[25:2], write_data[33:26], pad_lines[41:34],
    // h_position[50:42], zero pad
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // read_data[7:0], route[10:8], target_address[34:11], target_data[42:35],
    // fm_port[43], sound_reset_pulse[44], sound_cpu_stalled[45], zero pad
    output logic [OUT_W-1:0] m_tdata
);

    logic push, q_full, pop, head_valid, clr_done;
    cmd_t push_cmd, head_cmd;

    dcbd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .clr_done (clr_done),
        .push     (push),
        .cmd      (push_cmd)
    );

    dcbd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    dcbd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (head_valid),
        .q_cmd    (head_cmd),
        .pop      (pop),
        .clr_done (clr_done),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: test/testbench.sv
// Testbench for dual_cpu_bus_decoder: drives byte accesses from both CPUs and
// checks every decode result against an in-bench model of the console map.
// Depends on dcbd_pkg and the RTL under src.
module testbench;
    import dcbd_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    dual_cpu_bus_decoder dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // decoder model state
    logic [7:0] wram [WORK_RAM_DEPTH];
    logic [7:0] sram [SOUND_RAM_DEPTH];
    logic       busreq;
    logic       snd_rst;
    logic [7:0] bank;
    logic       padsel;

    result_t decode_q[$];
    int      errors;
    int      checked;
    int      send_idle_pct;
    int      recv_stall_pct;
    // long hold-off: the test bumps hold_req, the receiver process owns the count
    int      hold_req;
    int      hold_seen = 0;
    int      hold_off = 0;

    function automatic logic [7:0] snd_low_read(logic [15:0] off, logic [8:0] h);
        if (off < 16'h4000)
            return sram[int'(off[12:0]) % SOUND_RAM_DEPTH];
        if (off == HCOUNT_ADDR)
            return h[8:1];
        return 8'h00;
    endfunction

    function automatic void fm_fill(ref result_t r, input logic [1:0] slot,
                                    input logic [7:0] v);
        r.route          = slot[0] ? ROUTE_FM_DATA : ROUTE_FM_ADDR;
        r.fm_port        = slot[1];
        r.target_address = FM_BASE | 24'(slot);
        r.target_data    = v;
    endfunction

    function automatic void snd_low_write(ref result_t r, input logic [15:0] off,
                                          input logic [7:0] v);
        if (off < 16'h4000)
            sram[int'(off[12:0]) % SOUND_RAM_DEPTH] = v;
        else if (off < 16'h6000)
            fm_fill(r, off[1:0], v);
        else if (off < BANK_REG_END)
            bank = v;
    endfunction

    function automatic void bus_read(ref result_t r, input logic [23:0] a,
                                     input logic [7:0] pad, input logic [8:0] h);
        logic [15:0] off;
        off = {1'b0, a[14:0]};
        if (a < CART_END)
        begin
            r.route = ROUTE_CART_RD;
            r.target_address = a;
        end
        else if (a >= FM_BASE && a < FM_BASE + 4)
            r.read_data = 8'h00;
        else if (a >= SOUND_BASE && a < IO_BASE)
        begin
            if (busreq)
                r.read_data = 8'hFF;
            else if (off < 16'h4000)
                r.read_data = sram[int'(off[12:0]) % SOUND_RAM_DEPTH];
            else if (off >= 16'h8000)
                r.read_data = snd_low_read(off - 16'h8000, h);
            else
                r.read_data = 8'hFF;
        end
        else if (a >= IO_BASE && a < IO_BASE + 24'h20)
        begin
            case (a[4:0])
                IO_VERSION: r.read_data = VERSION_BYTE;
                IO_PAD: r.read_data = padsel ? {4'h3, pad[3:0]} : {4'h7, pad[7:4]};
                IO_CTRL_A, IO_CTRL_B: r.read_data = 8'h7F;
                default: r.read_data = 8'h00;
            endcase
        end
        else if (a >= VIDEO_BASE && a < VIDEO_BASE + 24'h20)
        begin
            r.route = ROUTE_VIDEO;
            r.target_address = a;
        end
        else if (a >= WORK_RAM_BASE)
            r.read_data = wram[int'(a[15:0]) % WORK_RAM_DEPTH];
        else
            r.read_data = 8'hFF;
    endfunction

    function automatic void bus_write(ref result_t r, input logic [23:0] a,
                                      input logic [7:0] v);
        logic [15:0] off;
        off = {1'b0, a[14:0]};
        if (a >= SRAM_BASE && a < SRAM_BASE + 24'h10000)
        begin
            r.route = ROUTE_SRAM_WR;
            r.target_address = a;
            r.target_data = v;
        end
        else if (a < CART_END)
            ;
        else if (a >= FM_BASE && a < FM_BASE + 4)
            fm_fill(r, a[1:0], v);
        else if (a >= SOUND_BASE && a < IO_BASE)
        begin
            if (!busreq)
            begin
                if (off < 16'h4000)
                    sram[int'(off[12:0]) % SOUND_RAM_DEPTH] = v;
                else if (off >= 16'h8000)
                    snd_low_write(r, off - 16'h8000, v);
            end
        end
        else if (a >= IO_BASE && a < IO_BASE + 24'h20)
        begin
            if (a[4:0] == IO_PAD_SEL)
                padsel = v[6];
        end
        else if (a == BUSREQ_ADDR_A || a == BUSREQ_ADDR_B)
            busreq = v[0];
        else if (a == RESET_REG)
        begin
            snd_rst = v[0];
            r.sound_reset_pulse = v[0];
        end
        else if (a == BANK_ADDR)
            bank = v;
        else if (a >= VIDEO_BASE && a < VIDEO_BASE + 24'h20)
        begin
            r.route = ROUTE_VIDEO;
            r.target_address = a;
            r.target_data = v;
        end
        else if (a >= WORK_RAM_BASE)
            wram[int'(a[15:0]) % WORK_RAM_DEPTH] = v;
    endfunction

    function automatic result_t decode_access(op_t op, logic [23:0] a, logic [7:0] v,
                                              logic [7:0] pad, logic [8:0] h);
        result_t     r;
        logic [15:0] s;
        logic [23:0] win;
        r = '0;
        s = a[15:0];
        win = {bank, 15'h0} + 24'(s - 16'h8000);
        case (op)
            OP_MAIN_RD: bus_read(r, a, pad, h);
            OP_MAIN_WR: bus_write(r, a, v);
            OP_SND_RD:
                if (s >= 16'h8000)
                    bus_read(r, win, pad, h);
                else if (s >= 16'h4000 && s < 16'h6000)
                    r.read_data = 8'h00;
                else
                    r.read_data = snd_low_read(s, h);
            default:
                if (s >= 16'h8000)
                    bus_write(r, win, v);
                else
                    snd_low_write(r, s, v);
        endcase
        r.sound_cpu_stalled = busreq | snd_rst;
        return r;
    endfunction

    // s_tvalid stays up between back-to-back transactions and drops only when idling
    task automatic send_access(op_t op, logic [23:0] a, logic [7:0] v = 8'($urandom),
                               logic [7:0] pad = 8'($urandom),
                               logic [8:0] h = 9'($urandom));
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tdata  <= {5'b0, h, pad, v, a, op};
        s_tvalid <= 1'b1;
        decode_q.push_back(decode_access(op, a, v, pad, h));
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[45:0]);
            if (decode_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transaction %h", got);
            end
            else
            begin
                want = decode_q.pop_front();
                checked++;
                if (got != want || m_tdata[OUT_W-1:46] != '0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp rd=%h rt=%0d ta=%h td=%h p=%b rp=%b st=%b",
                                 want.read_data, want.route, want.target_address,
                                 want.target_data, want.fm_port,
                                 want.sound_reset_pulse, want.sound_cpu_stalled,
                                 "\n          got rd=%h rt=%0d ta=%h td=%h p=%b rp=%b st=%b",
                                 got.read_data, got.route, got.target_address,
                                 got.target_data, got.fm_port,
                                 got.sound_reset_pulse, got.sound_cpu_stalled);
                end
            end
        end
    end

    // receiver stall, with a hold-off each time one is requested
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_off  <= 300;
            m_tready  <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            m_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [23:0] pick_addr();
        case ($urandom_range(11))
            0: return 24'($urandom_range(24'h3FFFFF));
            1: return 24'h200000 | 24'($urandom_range(16'hFFFF));
            2: return FM_BASE + 24'($urandom_range(3));
            3: return SOUND_BASE | 24'($urandom_range(16'hFFFF));
            4: return IO_BASE + 24'($urandom_range(31));
            5: return ($urandom_range(1)) ? BUSREQ_ADDR_B : BUSREQ_ADDR_A;
            6: return RESET_REG;
            7: return BANK_ADDR;
            8: return VIDEO_BASE + 24'($urandom_range(31));
            9, 10: return WORK_RAM_BASE | 24'($urandom_range(24'h1FFFFF));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic test_main_map();
        send_access(OP_MAIN_RD, 24'h000000);
        send_access(OP_MAIN_RD, 24'h3FFFFF);
        send_access(OP_MAIN_WR, 24'h200000, 8'hFF);
        send_access(OP_MAIN_WR, 24'h100000, 8'h5A);
        send_access(OP_MAIN_WR, 24'hFFFFFF, 8'hC3);
        send_access(OP_MAIN_RD, 24'hE0FFFF);
        send_access(OP_MAIN_RD, IO_BASE + 24'(IO_VERSION));
        send_access(OP_MAIN_WR, IO_BASE + 24'(IO_PAD_SEL), 8'h40);
        send_access(OP_MAIN_RD, IO_BASE + 24'(IO_PAD), 8'h00, 8'hA5);
        send_access(OP_MAIN_RD, IO_BASE + 24'(IO_CTRL_B));
        send_access(OP_MAIN_RD, 24'h800000);
        send_access(OP_MAIN_WR, VIDEO_BASE + 24'h1F, 8'h11);
        send_access(OP_MAIN_WR, FM_BASE + 24'h3, 8'h22);
        send_access(OP_MAIN_RD, FM_BASE + 24'h1);
    endtask

    task automatic test_sound_path();
        send_access(OP_MAIN_WR, RESET_REG, 8'h01);
        send_access(OP_MAIN_WR, SOUND_BASE | 24'h1FFF, 8'h77);
        send_access(OP_SND_RD, 24'hFF1FFF);
        send_access(OP_SND_RD, 24'h007F00, 8'h0, 8'h0, 9'h1FF);
        send_access(OP_SND_WR, 24'h004002, 8'h33);
        send_access(OP_SND_WR, 24'h006000, 8'hFF);
        send_access(OP_SND_RD, 24'h00FFFF);
        send_access(OP_MAIN_WR, BUSREQ_ADDR_A, 8'h01);
        send_access(OP_MAIN_RD, SOUND_BASE | 24'h1FFF);
        send_access(OP_MAIN_WR, BUSREQ_ADDR_B, 8'h00);
        send_access(OP_MAIN_WR, RESET_REG, 8'h00);
    endtask

    task automatic test_random(int n);
        op_t op;
        for (int i = 0; i < n; i++)
        begin
            op = op_t'($urandom_range(3));
            if (op == OP_MAIN_RD || op == OP_MAIN_WR)
                send_access(op, pick_addr());
            else if ($urandom_range(3) == 0)
                send_access(op, 24'($urandom));
            else
                send_access(op, {8'($urandom), 1'b1, 15'($urandom)} & 24'hFF80FF
                            | 24'($urandom_range(1) ? 16'h0000 : 16'h7F00));
        end
    endtask

    task automatic test_backpressure();
        hold_req++;
        recv_stall_pct = 0;
        send_idle_pct = 0;
        test_random(40);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        errors = 0;
        checked = 0;
        hold_req = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        busreq = 1'b0;
        snd_rst = 1'b1;
        bank = 8'h00;
        padsel = 1'b0;
        foreach (wram[i]) wram[i] = 8'h00;
        foreach (sram[i]) sram[i] = 8'h00;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_main_map();
        test_sound_path();
        test_random(350);
        send_idle_pct = 80;
        test_random(350);
        send_idle_pct = 0;
        recv_stall_pct = 80;
        test_random(350);
        send_idle_pct = 32;
        recv_stall_pct = 32;
        test_random(330);
        test_backpressure();
        s_tvalid <= 1'b0;

        while (decode_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("covered main/sound reads and writes over every map region, %0d results",
                 checked);
        $display("checked under idle, stall and long hold-off phases");
        if (errors == 0)
            $display("[dual_cpu_bus_decoder] OK");
        else
            $display("[dual_cpu_bus_decoder] ERROR");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("[dual_cpu_bus_decoder] ERROR");
        $finish;
    end
endmodule
